// ----- rtl/p2da_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// p2da_pkg
// Shared widths, constants, arctangent table and side-band type for the
// point-to-direction angle unit.
// ============================================================================
package p2da_pkg;

    // Coordinate and angle widths
    localparam int COORD_W = 16;
    localparam int DIFF_W  = 17;
    localparam int MAG_W   = 16;
    localparam int ANGLE_W = 16;

    // CORDIC configuration
    localparam int ROTATION_STEPS = 16;
    localparam int TABLE_LEN      = 24;
    localparam int CORDIC_STEPS   = (ROTATION_STEPS < TABLE_LEN) ? ROTATION_STEPS : TABLE_LEN;
    localparam int PRESCALE       = 14;

    // x/y datapath: magnitude plus prescale, CORDIC gain and sign headroom
    localparam int XY_W = MAG_W + PRESCALE + 6;
    // angle accumulator in 2^-32 turn, signed
    localparam int Z_W  = 34;
    // clamped first-quadrant angle, 0 .. 2^30
    localparam int ZC_W = 31;
    // folded angle after rounding, 0 .. 0x4000
    localparam int FOLD_W = ZC_W - 16;

    localparam logic signed [Z_W-1:0] Z_QUARTER  = Z_W'(64'sh4000_0000);
    localparam logic [ZC_W-1:0]       ZC_QUARTER = ZC_W'(32'h4000_0000);
    localparam logic [ZC_W-1:0]       ZC_ROUND   = ZC_W'(32'h0000_8000);

    // Binary angle codes
    localparam logic [ANGLE_W-1:0] ANGLE_ZERO   = 16'h0000;
    localparam logic [ANGLE_W-1:0] ANGLE_QUART  = 16'h4000;
    localparam logic [ANGLE_W-1:0] ANGLE_HALF   = 16'h8000;
    localparam logic [ANGLE_W-1:0] ANGLE_3QUART = 16'hC000;

    // atan(2^-i) in 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // Quadrant side band that travels alongside the CORDIC datapath
    typedef struct packed {
        logic               special;       // on an axis or equal points
        logic [ANGLE_W-1:0] special_angle;
        logic               dx_neg;
        logic               dy_neg;
    } t_quad;

endpackage
`default_nettype wire

// ----- rtl/p2da_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// p2da_if
// Valid/ready channels for point pairs in and binary angles out.
// ============================================================================
interface p2da_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [p2da_pkg::COORD_W-1:0] from_x;
    logic signed [p2da_pkg::COORD_W-1:0] from_y;
    logic signed [p2da_pkg::COORD_W-1:0] to_x;
    logic signed [p2da_pkg::COORD_W-1:0] to_y;

    modport source (output valid, output from_x, output from_y, output to_x, output to_y,
                    input ready);
    modport sink   (input valid, input from_x, input from_y, input to_x, input to_y,
                    output ready);
endinterface

interface p2da_out_if;
    logic                         valid;
    logic                         ready;
    logic [p2da_pkg::ANGLE_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface
`default_nettype wire

// ----- rtl/p2da_prep.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// p2da_prep
// Form coordinate differences, magnitudes and the quadrant side band.
// ============================================================================
module p2da_prep (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_valid,
    input  wire logic signed [p2da_pkg::COORD_W-1:0] i_from_x,
    input  wire logic signed [p2da_pkg::COORD_W-1:0] i_from_y,
    input  wire logic signed [p2da_pkg::COORD_W-1:0] i_to_x,
    input  wire logic signed [p2da_pkg::COORD_W-1:0] i_to_y,
    output      logic                                o_valid,
    output      logic [p2da_pkg::MAG_W-1:0]          o_ax,
    output      logic [p2da_pkg::MAG_W-1:0]          o_ay,
    output      p2da_pkg::t_quad                     o_quad
);

    logic signed [p2da_pkg::DIFF_W-1:0] dx;
    logic signed [p2da_pkg::DIFF_W-1:0] dy;
    logic [p2da_pkg::DIFF_W-1:0]        abs_dx;
    logic [p2da_pkg::DIFF_W-1:0]        abs_dy;
    p2da_pkg::t_quad                    n_quad;

    logic                               r_valid;
    logic [p2da_pkg::MAG_W-1:0]         r_ax;
    logic [p2da_pkg::MAG_W-1:0]         r_ay;
    p2da_pkg::t_quad                    r_quad;

    assign dx = p2da_pkg::DIFF_W'(i_to_x) - p2da_pkg::DIFF_W'(i_from_x);
    assign dy = p2da_pkg::DIFF_W'(i_from_y) - p2da_pkg::DIFF_W'(i_to_y);

    assign abs_dx = dx[p2da_pkg::DIFF_W-1] ? p2da_pkg::DIFF_W'(-dx) : p2da_pkg::DIFF_W'(dx);
    assign abs_dy = dy[p2da_pkg::DIFF_W-1] ? p2da_pkg::DIFF_W'(-dy) : p2da_pkg::DIFF_W'(dy);

    always_comb begin
        n_quad.dx_neg  = dx[p2da_pkg::DIFF_W-1];
        n_quad.dy_neg  = dy[p2da_pkg::DIFF_W-1];
        n_quad.special = (dx == '0) || (dy == '0);
        // axis directions are exact
        if (dx == '0) begin
            if (dy == '0) begin
                n_quad.special_angle = p2da_pkg::ANGLE_ZERO;
            end else if (dy[p2da_pkg::DIFF_W-1]) begin
                n_quad.special_angle = p2da_pkg::ANGLE_3QUART;
            end else begin
                n_quad.special_angle = p2da_pkg::ANGLE_QUART;
            end
        end else if (dx[p2da_pkg::DIFF_W-1]) begin
            n_quad.special_angle = p2da_pkg::ANGLE_HALF;
        end else begin
            n_quad.special_angle = p2da_pkg::ANGLE_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax   <= abs_dx[p2da_pkg::MAG_W-1:0];
            r_ay   <= abs_dy[p2da_pkg::MAG_W-1:0];
            r_quad <= n_quad;
        end
    end

    assign o_valid = r_valid;
    assign o_ax    = r_ax;
    assign o_ay    = r_ay;
    assign o_quad  = r_quad;

endmodule
`default_nettype wire

// ----- rtl/p2da_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// p2da_cordic
// Vectoring CORDIC, one registered micro-rotation per pipeline stage.
// ============================================================================
module p2da_cordic (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic [p2da_pkg::MAG_W-1:0]        i_ax,
    input  wire logic [p2da_pkg::MAG_W-1:0]        i_ay,
    input  wire p2da_pkg::t_quad                   i_quad,
    output      logic                              o_valid,
    output      logic signed [p2da_pkg::Z_W-1:0]   o_z,
    output      p2da_pkg::t_quad                   o_quad
);

    localparam int N    = p2da_pkg::CORDIC_STEPS;
    localparam int XY_W = p2da_pkg::XY_W;
    localparam int Z_W  = p2da_pkg::Z_W;
    localparam int PAD  = XY_W - p2da_pkg::MAG_W - p2da_pkg::PRESCALE;

    logic                    r_valid [N];
    logic signed [XY_W-1:0]  r_x     [N];
    logic signed [XY_W-1:0]  r_y     [N];
    logic signed [Z_W-1:0]   r_z     [N];
    p2da_pkg::t_quad         r_quad  [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic                   v_in;
        logic signed [XY_W-1:0] x_in;
        logic signed [XY_W-1:0] y_in;
        logic signed [Z_W-1:0]  z_in;
        p2da_pkg::t_quad        q_in;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        logic signed [Z_W-1:0]  step_angle;
        logic                   y_pos;

        if (k == 0) begin : g_head
            assign v_in = i_valid;
            assign x_in = $signed({{PAD{1'b0}}, i_ax, {p2da_pkg::PRESCALE{1'b0}}});
            assign y_in = $signed({{PAD{1'b0}}, i_ay, {p2da_pkg::PRESCALE{1'b0}}});
            assign z_in = '0;
            assign q_in = i_quad;
        end else begin : g_body
            assign v_in = r_valid[k-1];
            assign x_in = r_x[k-1];
            assign y_in = r_y[k-1];
            assign z_in = r_z[k-1];
            assign q_in = r_quad[k-1];
        end

        // floor shift by the stage index
        assign xs         = x_in >>> k;
        assign ys         = y_in >>> k;
        assign step_angle = $signed({{(Z_W-32){1'b0}}, p2da_pkg::ATAN_TURNS[k]});
        assign y_pos      = !y_in[XY_W-1] && (y_in != '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (y_pos) begin
                    r_x[k] <= x_in + ys;
                    r_y[k] <= y_in - xs;
                    r_z[k] <= z_in + step_angle;
                end else begin
                    r_x[k] <= x_in - ys;
                    r_y[k] <= y_in + xs;
                    r_z[k] <= z_in - step_angle;
                end
                r_quad[k] <= q_in;
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_z     = r_z[N-1];
    assign o_quad  = r_quad[N-1];

endmodule
`default_nettype wire

// ----- rtl/p2da_unfold.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// p2da_unfold
// Clamp and round the folded angle, place it in its quadrant, hold the result.
// ============================================================================
module p2da_unfold (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire logic signed [p2da_pkg::Z_W-1:0] i_z,
    input  wire p2da_pkg::t_quad                 i_quad,
    output      logic                            o_valid,
    output      logic [p2da_pkg::ANGLE_W-1:0]    o_angle
);

    logic [p2da_pkg::ZC_W-1:0]    zc;
    logic [p2da_pkg::ZC_W-1:0]    zr;
    logic [p2da_pkg::ANGLE_W-1:0] fold;
    logic [p2da_pkg::ANGLE_W-1:0] n_angle;

    logic                         r_valid;
    logic [p2da_pkg::ANGLE_W-1:0] r_angle;

    always_comb begin
        if (i_z[p2da_pkg::Z_W-1]) begin
            zc = '0;
        end else if (i_z > p2da_pkg::Z_QUARTER) begin
            zc = p2da_pkg::ZC_QUARTER;
        end else begin
            zc = i_z[p2da_pkg::ZC_W-1:0];
        end
    end

    // round half up to 2^-16 turn
    assign zr   = zc + p2da_pkg::ZC_ROUND;
    assign fold = {1'b0, zr[p2da_pkg::ZC_W-1:16]};

    always_comb begin
        if (i_quad.special) begin
            n_angle = i_quad.special_angle;
        end else begin
            case ({i_quad.dx_neg, i_quad.dy_neg})
                2'b00:   n_angle = fold;
                2'b10:   n_angle = p2da_pkg::ANGLE_HALF - fold;
                2'b11:   n_angle = p2da_pkg::ANGLE_HALF + fold;
                default: n_angle = p2da_pkg::ANGLE_ZERO - fold;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_valid = r_valid;
    assign o_angle = r_angle;

endmodule
`default_nettype wire

// ----- rtl/points_to_direction_angle_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// points_to_direction_angle_unit
// Direction from one screen point to another as a 16-bit binary angle.
// ============================================================================
// Takes one point pair per transfer and returns one angle per transfer, in
// order: angle = atan2(from_y - to_y, to_x - from_x) as value/65536 of a full
// turn, counter-clockwise with y growing downward. Equal points give 0 and
// points on an axis give exact multiples of a quarter turn. The unit accepts
// a new pair every clock cycle while the output is not stalled. The pipeline
// has one stage that forms differences and magnitudes, one stage per CORDIC
// micro-rotation, and one stage that unfolds the quadrant into the output
// register. The whole pipeline advances together, so throughput is one pair
// per cycle whenever the output side takes its transfer; while the output
// holds a result that is not taken, every stage holds and input ready drops.
// ============================================================================
module points_to_direction_angle_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    p2da_in_if.sink     i_in,
    p2da_out_if.source  o_out
);

    logic                             en;
    logic                             prep_valid;
    logic [p2da_pkg::MAG_W-1:0]       prep_ax;
    logic [p2da_pkg::MAG_W-1:0]       prep_ay;
    p2da_pkg::t_quad                  prep_quad;
    logic                             cordic_valid;
    logic signed [p2da_pkg::Z_W-1:0]  cordic_z;
    p2da_pkg::t_quad                  cordic_quad;

    // Advance the pipeline unless a finished result is stuck at the output.
    assign en          = !o_out.valid || o_out.ready;
    assign i_in.ready  = en;

    // Differences, magnitudes and quadrant
    p2da_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in.valid),
        .i_from_x (i_in.from_x),
        .i_from_y (i_in.from_y),
        .i_to_x   (i_in.to_x),
        .i_to_y   (i_in.to_y),
        .o_valid  (prep_valid),
        .o_ax     (prep_ax),
        .o_ay     (prep_ay),
        .o_quad   (prep_quad)
    );

    // First-quadrant angle by CORDIC vectoring
    p2da_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prep_valid),
        .i_ax    (prep_ax),
        .i_ay    (prep_ay),
        .i_quad  (prep_quad),
        .o_valid (cordic_valid),
        .o_z     (cordic_z),
        .o_quad  (cordic_quad)
    );

    // Clamp, round, unfold and hold the result
    p2da_unfold u_unfold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cordic_valid),
        .i_z     (cordic_z),
        .i_quad  (cordic_quad),
        .o_valid (o_out.valid),
        .o_angle (o_out.angle)
    );

endmodule
`default_nettype wire

// ----- rtl/p2da_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// p2da_checker
// Port-level checks of the point-to-direction angle unit.
// ============================================================================
module p2da_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_ready,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_ready,
    input  wire logic [p2da_pkg::ANGLE_W-1:0] i_out_angle
);

    // Reset empties the pipeline: no result right after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // An empty output stage never blocks input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // A stalled result blocks input so nothing is overwritten.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input taken while result stalled");

    // A stalled result holds its value.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_angle)))
        else $error("stalled result changed");

endmodule

bind points_to_direction_angle_unit p2da_checker u_p2da_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_angle (o_out.angle)
);
`default_nettype wire
